/* hw/rtl/pts_pkg.sv */
// shared types and constants for the polynomial term store and evaluator
package pts_pkg;

    localparam int MAX_TERMS_DEF = 16;

    // item modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_EVAL  = 2'd1;
    localparam logic [1:0] MODE_DIFF  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic signed [31:0]  term_coeff;
        logic [3:0]          term_degree;
        logic signed [31:0]  point_x;
    } item_t;

    typedef struct packed {
        logic signed [63:0]  value;
        logic [1:0]          status;
    } result_t;

    // datapath step controls from the sequencer
    typedef struct packed {
        logic start;    // clear accumulator and saturation flag
        logic mul;      // horner: partial products of acc * x
        logic cmb;      // horner: sum partial products, scale down
        logic add;      // horner: clamp product, add coefficient term
        logic dmul;     // derivative: coefficient times degree
        logic dwr;      // derivative: clamped coefficient written back
    } mac_ctl_t;

endpackage

/* hw/rtl/pts_ram.sv */
// generic single-write, single-read memory with registered read data
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/pts_mac.sv */
// arithmetic datapath: q16.16 horner step in three stages and derivative scaling
module pts_mac #(
    parameter int IDX_W = 4
) (
    input  logic               clk,
    input  pts_pkg::mac_ctl_t  ctl,
    input  logic signed [31:0] x,
    input  logic signed [31:0] coeff,
    input  logic [IDX_W-1:0]   idx,
    output logic signed [63:0] acc,
    output logic               sat,
    output logic signed [31:0] dcoeff
);

    import pts_pkg::*;

    localparam int DPW = 33 + IDX_W;
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] C_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN   = 32'sh8000_0000;

    logic signed [63:0]    acc_reg;
    logic signed [63:0]    acc_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic signed [64:0]    plo_reg;
    logic signed [64:0]    plo_next;
    logic signed [63:0]    phi_reg;
    logic signed [63:0]    phi_next;
    logic                  bias_reg;
    logic signed [79:0]    q_reg;
    logic [95:0]           psum;
    logic                  ovf_m;
    logic signed [63:0]    prod;
    logic signed [63:0]    term;
    logic [64:0]           asum;
    logic                  ovf_a;
    logic signed [DPW-1:0] dp_reg;
    logic signed [DPW-1:0] dp_next;
    logic                  dovf;

    // partial products: low word unsigned, high word signed
    assign plo_next = $signed({1'b0, acc_reg[31:0]}) * x;
    assign phi_next = $signed(acc_reg[63:32]) * x;

    // full product plus rounding bias so the shift truncates toward zero
    assign psum = {phi_reg, 32'b0} + {{31{plo_reg[64]}}, plo_reg}
                + {80'b0, {16{bias_reg}}};

    // clamp shifted product, then saturating add of coefficient * 65536
    assign ovf_m = !((&q_reg[79:63]) || !(|q_reg[79:63]));
    assign prod  = ovf_m ? (q_reg[79] ? ACC_MIN : ACC_MAX) : q_reg[63:0];
    assign term  = {{16{coeff[31]}}, coeff, 16'b0};
    assign asum  = {prod[63], prod} + {term[63], term};
    assign ovf_a = asum[64] ^ asum[63];

    // derivative product and clamp to 32 bits
    assign dp_next = $signed(coeff) * $signed({1'b0, idx});
    assign dovf    = !((&dp_reg[DPW-1:31]) || !(|dp_reg[DPW-1:31]));
    assign dcoeff  = dovf ? (dp_reg[DPW-1] ? C_MIN : C_MAX) : dp_reg[31:0];

    // accumulator and sticky saturation flag
    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (ctl.start)
        begin
            acc_next = '0;
            sat_next = 1'b0;
        end
        else if (ctl.add)
        begin
            acc_next = ovf_a ? (asum[64] ? ACC_MIN : ACC_MAX) : asum[63:0];
            sat_next = sat_reg | ovf_m | ovf_a;
        end
        else if (ctl.dwr)
        begin
            sat_next = sat_reg | dovf;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sat_reg <= sat_next;
        if (ctl.mul)
        begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            bias_reg <= acc_reg[63] ^ x[31];
        end
        if (ctl.cmb)
        begin
            q_reg <= psum[95:16];
        end
        if (ctl.dmul)
        begin
            dp_reg <= dp_next;
        end
    end

    assign acc = acc_reg;
    assign sat = sat_reg;

endmodule

/* hw/rtl/polynomial_term_store_eval_top.sv */
// top level: polynomial term store with horner evaluation and in-place derivative
//
// Items arrive on item_valid/item_stall/item, results leave on
// result_valid/result_stall/result; a transaction completes at a clock edge
// with valid high and stall low. Every item yields exactly one result.
// Coefficients sit in a synchronous RAM of MAX_TERMS words; present flags
// sit in flip-flops, and an entry that is not present reads as zero.
// Add term and clear register their result at the accepting edge. Evaluate
// runs one RAM read and a three-stage multiply, combine and saturating add
// per degree, one degree after another, as each horner step depends on the
// last. Differentiate reads, scales and writes back each degree in turn
// through the single RAM port pair. One item is in work at a time.
// The result register holds a finished result while result_stall is high;
// an evaluate or differentiate can be accepted meanwhile, and finishes
// once the register is free. Reset empties the store at once by clearing
// the present flags; no clearing pass is needed.
module polynomial_term_store_eval_top #(
    parameter int MAX_TERMS = pts_pkg::MAX_TERMS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pts_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pts_pkg::result_t result
);

    import pts_pkg::*;

    localparam int AW   = $clog2(MAX_TERMS);
    localparam int DEGW = (AW > 4) ? AW : 4;
    localparam logic [AW-1:0] LAST = AW'(MAX_TERMS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EV_MUL = 3'd1;
    localparam logic [2:0] ST_EV_CMB = 3'd2;
    localparam logic [2:0] ST_EV_ADD = 3'd3;
    localparam logic [2:0] ST_DF_RD  = 3'd4;
    localparam logic [2:0] ST_DF_MUL = 3'd5;
    localparam logic [2:0] ST_DF_WR  = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        idx_next;
    logic signed [31:0]   x_reg;
    logic                 is_eval_reg;
    logic [MAX_TERMS-1:0] present_reg;
    logic [MAX_TERMS-1:0] present_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    result_t              res_reg;
    result_t              res_next;

    logic                 item_fire;
    logic                 slot_free;
    logic                 quick_mode;
    logic [DEGW:0]        deg_wide;
    logic [AW-1:0]        deg_addr;
    logic                 deg_ok;
    mac_ctl_t             ctl;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [31:0]          wr_data;
    logic                 rd_en;
    logic [31:0]          rd_data;
    logic signed [31:0]   coeff_rd;
    logic signed [63:0]   acc;
    logic                 sat;
    logic signed [31:0]   dcoeff;

    // input handshake: add and clear need the result register right away
    assign slot_free  = !res_valid_reg || !result_stall;
    assign quick_mode = (item.mode == MODE_ADD) || (item.mode == MODE_CLEAR);
    assign item_stall = (state_reg != ST_IDLE) || (quick_mode && !slot_free);
    assign item_fire  = item_valid && !item_stall;

    // degree range check and slot address for add term
    assign deg_wide = (DEGW + 1)'(item.term_degree);
    assign deg_addr = deg_wide[AW-1:0];
    assign deg_ok   = (deg_wide < (DEGW + 1)'(MAX_TERMS)) && !present_reg[deg_addr];

    // coefficient of an absent slot reads as zero
    assign coeff_rd = present_reg[idx_reg] ? $signed(rd_data) : 32'sd0;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        present_next   = present_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        ctl            = '0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg - AW'(1);
        wr_data        = dcoeff;
        rd_en          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    unique case (item.mode)
                        MODE_ADD:
                        begin
                            res_valid_next = 1'b1;
                            res_next.value = '0;
                            res_next.status = deg_ok ? STATUS_OK : STATUS_IGNORED;
                            if (deg_ok)
                            begin
                                wr_en                  = 1'b1;
                                wr_addr                = deg_addr;
                                wr_data                = item.term_coeff;
                                present_next[deg_addr] = 1'b1;
                            end
                        end
                        MODE_EVAL:
                        begin
                            ctl.start  = 1'b1;
                            idx_next   = LAST;
                            state_next = ST_EV_MUL;
                        end
                        MODE_DIFF:
                        begin
                            ctl.start  = 1'b1;
                            idx_next   = AW'(1);
                            state_next = ST_DF_RD;
                        end
                        MODE_CLEAR:
                        begin
                            res_valid_next  = 1'b1;
                            res_next.value  = '0;
                            res_next.status = STATUS_OK;
                            present_next    = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EV_MUL:
            begin
                rd_en      = 1'b1;
                ctl.mul    = 1'b1;
                state_next = ST_EV_CMB;
            end
            ST_EV_CMB:
            begin
                ctl.cmb    = 1'b1;
                state_next = ST_EV_ADD;
            end
            ST_EV_ADD:
            begin
                ctl.add = 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_EV_MUL;
                end
            end
            ST_DF_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_DF_MUL;
            end
            ST_DF_MUL:
            begin
                ctl.dmul   = 1'b1;
                state_next = ST_DF_WR;
            end
            ST_DF_WR:
            begin
                ctl.dwr = 1'b1;
                wr_en   = 1'b1;
                if (idx_reg == LAST)
                begin
                    present_next = present_reg >> 1;
                    state_next   = ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_DF_RD;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_next.value  = is_eval_reg ? acc : 64'sd0;
                    res_next.status = sat ? STATUS_SAT : STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            present_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            present_reg   <= present_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (item_fire)
        begin
            x_reg       <= item.point_x;
            is_eval_reg <= (item.mode == MODE_EVAL);
        end
    end

    // coefficient store
    pts_ram #(
        .WIDTH (32),
        .DEPTH (MAX_TERMS)
    ) u_coeff_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // arithmetic datapath
    pts_mac #(
        .IDX_W (AW)
    ) u_mac (
        .clk    (clk),
        .ctl    (ctl),
        .x      (x_reg),
        .coeff  (coeff_rd),
        .idx    (idx_reg),
        .acc    (acc),
        .sat    (sat),
        .dcoeff (dcoeff)
    );

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // a clear transaction empties the store
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.mode == MODE_CLEAR |=> present_reg == '0)
        else $error("store not empty after clear");

    // an add term with an out-of-range degree is reported as ignored
    a_add_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.mode == MODE_ADD && deg_wide >= (DEGW + 1)'(MAX_TERMS)
        |=> result_valid && result.status == STATUS_IGNORED)
        else $error("out-of-range degree not ignored");

    // after a derivative the top slot is empty
    a_diff_top: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && !is_eval_reg |-> !present_reg[MAX_TERMS-1])
        else $error("top slot present after derivative");

    // the sweep index stays inside the store
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> idx_reg <= LAST)
        else $error("sweep index beyond store");

endmodule

/* verif/tb.sv */
// self-checking testbench for the polynomial term store and horner evaluator
module tb;
    import pts_pkg::*;

    localparam int NT = pts_pkg::MAX_TERMS_DEF;
    localparam int ITEM_TARGET = 750;
    localparam logic signed [63:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VALUE_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] COEFF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COEFF_MIN = 32'sh8000_0000;

    // scoreboard: shadow copy of the term store plus the queue of expected results
    class term_store_scoreboard;
        logic signed [31:0] shadow_coeff [NT];
        bit                 shadow_present [NT];
        result_t            outstanding_results [$];
        int                 failures;
        int                 checked;
        int                 sat_seen;
        int                 ignored_seen;
        int                 mode_count [4];

        function void clear_shadow();
            foreach (shadow_coeff[i])
            begin
                shadow_coeff[i] = '0;
                shadow_present[i] = 1'b0;
            end
        endfunction

        function int pending();
            return outstanding_results.size();
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10)
                $display("mismatch: %s", what);
        endfunction

        // update the shadow store for one accepted transaction and queue its result
        function void apply_item(item_t it);
            result_t              want;
            logic signed [63:0]   acc;
            logic signed [63:0]   term;
            logic signed [63:0]   prod64;
            logic signed [127:0]  wide_a;
            logic signed [127:0]  wide_x;
            logic signed [127:0]  prod;
            logic signed [127:0]  mag;
            logic [127:0]         shifted;
            logic [64:0]          sum;
            logic                 neg;
            logic                 sat;
            int                   d;

            want.value = '0;
            want.status = STATUS_OK;
            sat = 1'b0;
            mode_count[it.mode]++;
            case (it.mode)
                MODE_ADD:
                begin
                    if (int'(it.term_degree) >= NT || shadow_present[it.term_degree])
                        want.status = STATUS_IGNORED;
                    else
                    begin
                        shadow_coeff[it.term_degree] = it.term_coeff;
                        shadow_present[it.term_degree] = 1'b1;
                    end
                end
                MODE_EVAL:
                begin
                    acc = '0;
                    for (d = NT - 1; d >= 0; d--)
                    begin
                        // exact product, scaled down with truncation toward zero
                        wide_a = acc;
                        wide_x = it.point_x;
                        prod = wide_a * wide_x;
                        neg = prod[127];
                        mag = neg ? -prod : prod;
                        shifted = mag >> 16;
                        if (shifted[127:64] != '0 ||
                            (shifted[63] && (!neg || shifted[62:0] != '0)))
                        begin
                            sat = 1'b1;
                            acc = neg ? VALUE_MIN : VALUE_MAX;
                        end
                        else
                            acc = neg ? -shifted[63:0] : shifted[63:0];
                        // add the coefficient in q16.16, clamped to 64 bits
                        term = {{16{shadow_coeff[d][31]}}, shadow_coeff[d], 16'h0000};
                        sum = {acc[63], acc} + {term[63], term};
                        if (sum[64] != sum[63])
                        begin
                            sat = 1'b1;
                            acc = sum[64] ? VALUE_MIN : VALUE_MAX;
                        end
                        else
                            acc = sum[63:0];
                    end
                    want.value = acc;
                    want.status = sat ? STATUS_SAT : STATUS_OK;
                end
                MODE_DIFF:
                begin
                    for (d = 1; d < NT; d++)
                    begin
                        prod64 = $signed({{32{shadow_coeff[d][31]}}, shadow_coeff[d]})
                                 * longint'(d);
                        if (prod64 > 64'sh7FFF_FFFF)
                        begin
                            prod64 = 64'sh7FFF_FFFF;
                            sat = 1'b1;
                        end
                        else if (prod64 < -64'sh8000_0000)
                        begin
                            prod64 = -64'sh8000_0000;
                            sat = 1'b1;
                        end
                        shadow_coeff[d - 1] = prod64[31:0];
                        shadow_present[d - 1] = shadow_present[d];
                    end
                    shadow_coeff[NT - 1] = '0;
                    shadow_present[NT - 1] = 1'b0;
                    want.status = sat ? STATUS_SAT : STATUS_OK;
                end
                default:
                    clear_shadow();
            endcase
            outstanding_results.push_back(want);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(result_t got);
            result_t want;

            if (got.status == STATUS_SAT)
                sat_seen++;
            if (got.status == STATUS_IGNORED)
                ignored_seen++;
            if (outstanding_results.size() == 0)
            begin
                note_failure($sformatf("result with nothing outstanding: value %0d status %0d",
                                       got.value, got.status));
                return;
            end
            want = outstanding_results.pop_front();
            checked++;
            if (got.value !== want.value)
                note_failure($sformatf("value expected %0d (0x%h) got %0d (0x%h)",
                                       want.value, want.value, got.value, got.value));
            if (got.status !== want.status)
                note_failure($sformatf("status expected %0d got %0d",
                                       want.status, got.status));
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    term_store_scoreboard sb;
    int  items_sent;
    int  hold_req;
    bit  quiet_tail;

    polynomial_term_store_eval_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // overall time limit
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // offer one transaction and hold it until accepted, then maybe idle
    task automatic send_item(input item_t it);
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.apply_item(it);
        items_sent++;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    function automatic item_t noise_item();
        item_t it;

        it.mode = 2'($urandom);
        it.term_coeff = $urandom;
        it.term_degree = 4'($urandom);
        it.point_x = $urandom;
        return it;
    endfunction

    task automatic add_term(input logic signed [31:0] coeff, input logic [3:0] degree);
        item_t it;

        it = noise_item();
        it.mode = MODE_ADD;
        it.term_coeff = coeff;
        it.term_degree = degree;
        send_item(it);
    endtask

    task automatic evaluate(input logic signed [31:0] x);
        item_t it;

        it = noise_item();
        it.mode = MODE_EVAL;
        it.point_x = x;
        send_item(it);
    endtask

    task automatic differentiate();
        item_t it;

        it = noise_item();
        it.mode = MODE_DIFF;
        send_item(it);
    endtask

    task automatic clear_store();
        item_t it;

        it = noise_item();
        it.mode = MODE_CLEAR;
        send_item(it);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic wait_all_results();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_coeff();
        case ($urandom_range(0, 5))
            0: return COEFF_MAX;
            1: return COEFF_MIN;
            2: return $signed(32'($urandom_range(0, 16)) - 32'd8);
            3: return 32'($signed(16'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    // evaluation points: zero, extremes, around unity, small fractions, anything
    function automatic logic signed [31:0] pick_x();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return COEFF_MAX;
            2: return COEFF_MIN;
            3, 4: return $signed(32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000);
            5: return $signed(32'($urandom_range(0, 32'h1_0000)) - 32'h8000);
            default: return $urandom;
        endcase
    endfunction

    // result side: check transactions, random stall bursts, one long hold-off
    initial
    begin
        int stall_left;
        int hold_left;

        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                sb.check_result(result);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // item side: reset, directed cases, random sequences, wrap-up
    initial
    begin
        int kind;
        bit held;
        bit drained;

        held = 1'b0;
        drained = 1'b0;
        sb = new;
        sb.clear_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, duplicate degrees, extreme coefficients and points
        evaluate('0);
        add_term(COEFF_MIN, 4'd0);
        add_term(32'sd5, 4'd0);
        add_term(COEFF_MAX, 4'd15);
        add_term(-32'sd1, 4'd15);
        evaluate(COEFF_MAX);
        evaluate(COEFF_MIN);
        evaluate(32'sh0001_0000);
        // top coefficient times fifteen overflows
        differentiate();
        evaluate(32'sh0001_0000);
        clear_store();
        evaluate(COEFF_MAX);
        // x + 3 at 2.0 and -1.5, then differentiate down to nothing
        add_term(32'sd1, 4'd1);
        add_term(32'sd3, 4'd0);
        evaluate(32'sh0002_0000);
        evaluate(-32'sd98304);
        differentiate();
        differentiate();
        differentiate();
        evaluate(32'sh0003_0000);
        // lands exactly on the negative bound without saturating
        clear_store();
        add_term(COEFF_MIN, 4'd8);
        evaluate(-32'sd262144);
        clear_store();

        // random part: mostly well-formed build/evaluate sequences, some noise
        while (items_sent < ITEM_TARGET)
        begin
            quiet_tail = (items_sent >= ITEM_TARGET - 100);
            if (!held && items_sent >= 300)
            begin
                // result side holds off while items keep coming
                held = 1'b1;
                hold_req = 400;
                repeat (4) add_term(pick_coeff(), 4'($urandom));
                repeat (8) evaluate(pick_x());
            end
            else if (!drained && items_sent >= 500)
            begin
                drained = 1'b1;
                wait_all_results();
            end
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                if ($urandom_range(0, 2) != 0)
                    clear_store();
                repeat ($urandom_range(1, 8)) add_term(pick_coeff(), 4'($urandom));
                repeat ($urandom_range(1, 3)) evaluate(pick_x());
                if ($urandom_range(0, 2) == 0)
                begin
                    repeat ($urandom_range(1, 2)) differentiate();
                    evaluate(pick_x());
                end
            end
            else
                repeat ($urandom_range(1, 4)) send_item(noise_item());
        end

        wait_all_results();
        repeat (60) @(posedge clk);

        $display("summary: %0d transactions in (%0d add, %0d evaluate, %0d differentiate, %0d clear)",
                 items_sent, sb.mode_count[MODE_ADD], sb.mode_count[MODE_EVAL],
                 sb.mode_count[MODE_DIFF], sb.mode_count[MODE_CLEAR]);
        $display("summary: %0d results checked, %0d saturated, %0d ignored terms, %0d mismatches",
                 sb.checked, sb.sat_seen, sb.ignored_seen, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
